[src/egd_pkg.sv]
// Shared types, microcode format and control program for the Egyptian divider.
`default_nettype none
package egd_pkg;

    localparam int STEP_BITS = 3;
    typedef logic [STEP_BITS-1:0] t_step;

    // Program addresses
    localparam t_step STEP_LOAD = 3'd0;
    localparam t_step STEP_CHKZ = 3'd1;
    localparam t_step STEP_NORM = 3'd2;
    localparam t_step STEP_SUB  = 3'd3;
    localparam t_step STEP_EMIT = 3'd4;
    localparam t_step STEP_LAST = STEP_EMIT;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SHL,
        OP_SUBSHR,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NO_INPUT,
        COND_ERR,
        COND_LT,
        COND_WGT_GT1,
        COND_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        FIRE_ALWAYS,
        FIRE_IF,
        FIRE_UNLESS
    } t_fire;

    // One control word: operation, test, when the operation fires, jump target.
    // A true test jumps to target; otherwise fall through to the next step, or from the last step back to load.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_fire fire;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic err;
        logic lt;
        logic wgt_gt1;
    } t_dp_flags;

    typedef struct packed {
        logic      in_valid;
        logic      out_busy;
        t_dp_flags flags;
    } t_status;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    function automatic t_uword program_word(input t_step step);
        t_uword w;
        case (step)
            STEP_LOAD: w = '{OP_LOAD,   COND_NO_INPUT, FIRE_UNLESS, STEP_LOAD};
            STEP_CHKZ: w = '{OP_NOP,    COND_ERR,      FIRE_ALWAYS, STEP_EMIT};
            STEP_NORM: w = '{OP_SHL,    COND_LT,       FIRE_IF,     STEP_NORM};
            STEP_SUB:  w = '{OP_SUBSHR, COND_WGT_GT1,  FIRE_ALWAYS, STEP_SUB};
            STEP_EMIT: w = '{OP_EMIT,   COND_OUT_BUSY, FIRE_UNLESS, STEP_EMIT};
            default:   w = '{OP_NOP,    COND_ERR,      FIRE_ALWAYS, STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[src/egyptian_divider.sv]
// Top level of the Egyptian (shift and subtract) unsigned divider.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+---------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: dividend, divisor (zero padded)
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: quotient; tuser: divide_error
//
//  One division runs from transfer in to result register through k doublings, where k
//  is the number of doublings needed to lift the divisor to the dividend (k is at
//  most DATA_WIDTH), then halving subtract steps down to weight one; a zero divisor
//  skips straight to the emit step. The work is done by the single shift/subtract
//  unit, one step per cycle, under the microcode step counter. Reset (synchronous,
//  active low) returns the program to its load step and empties the output register.
//  The output register holds a result while m_axis stalls; the next item is taken
//  meanwhile and its result waits in the emit step until the register frees.
`default_nettype none
module egyptian_divider
    import egd_pkg::*;
#(
    parameter int DATA_WIDTH = 31
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // [DATA_WIDTH-1:0] dividend, [2*DATA_WIDTH-1:DATA_WIDTH] divisor, rest zero
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [DATA_WIDTH-1:0] quotient, rest zero
    output logic [((DATA_WIDTH+7)/8)*8-1:0]             m_axis_tdata,
    // [0] divide_error
    output logic                                        m_axis_tuser
);

    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

    t_ctrl                 ctrl;
    t_status               status;
    t_dp_flags             flags;
    logic [DATA_WIDTH-1:0] quotient;

    // Sequencer sees input presence, output backpressure and datapath tests
    assign status.in_valid = s_axis_tvalid;
    assign status.out_busy = m_axis_tvalid && !m_axis_tready;
    assign status.flags    = flags;

    // Ready only in the load step; the load fires exactly on a transfer
    assign s_axis_tready = (ctrl.op == OP_LOAD);

    egd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    egd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_dividend     (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_divisor      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_out_ready    (m_axis_tready),
        .o_flags        (flags),
        .o_out_valid    (m_axis_tvalid),
        .o_quotient     (quotient),
        .o_divide_error (m_axis_tuser)
    );

    // Pad the quotient to whole bytes
    assign m_axis_tdata = OUT_W'(quotient);

endmodule
`default_nettype wire

[src/egd_seq.sv]
// Microcode sequencer: step counter, program table and condition select.
`default_nettype none
module egd_seq
    import egd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_ctrl        o_ctrl
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword w;
    logic   cond;

    always_comb begin
        w = program_word(r_pc);
        case (w.cond)
            COND_NO_INPUT: cond = !i_status.in_valid;
            COND_ERR:      cond = i_status.flags.err;
            COND_LT:       cond = i_status.flags.lt;
            COND_WGT_GT1:  cond = i_status.flags.wgt_gt1;
            COND_OUT_BUSY: cond = i_status.out_busy;
            default:       cond = 1'b0;
        endcase

        o_ctrl.op = w.op;
        case (w.fire)
            FIRE_ALWAYS: o_ctrl.fire = 1'b1;
            FIRE_IF:     o_ctrl.fire = cond;
            FIRE_UNLESS: o_ctrl.fire = !cond;
            default:     o_ctrl.fire = 1'b0;
        endcase

        if (cond) begin
            n_pc = w.target;
        end else if (r_pc == STEP_LAST) begin
            n_pc = STEP_LOAD;
        end else begin
            n_pc = r_pc + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

[src/egd_datapath.sv]
// Divider datapath: remainder, scaled divisor, weight, quotient and output register.
`default_nettype none
module egd_datapath
    import egd_pkg::*;
#(
    parameter int DATA_WIDTH = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl                 i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    input  wire logic                  i_out_ready,
    output t_dp_flags                  o_flags,
    output logic                       o_out_valid,
    output logic [DATA_WIDTH-1:0]      o_quotient,
    output logic                       o_divide_error
);

    localparam int WW = DATA_WIDTH + 1;

    logic [WW-1:0]         r_rem, r_scaled, r_weight;
    logic [DATA_WIDTH-1:0] r_quo;
    logic                  r_err;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_quo;
    logic                  r_out_err;

    logic fits;

    assign fits            = (r_scaled <= r_rem);
    assign o_flags.err     = r_err;
    assign o_flags.lt      = (r_scaled < r_rem);
    assign o_flags.wgt_gt1 = (r_weight > WW'(1));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_rem    <= {1'b0, i_dividend};
                    r_scaled <= {1'b0, i_divisor};
                    r_weight <= WW'(1);
                    r_quo    <= '0;
                    r_err    <= (i_divisor == '0);
                end
                OP_SHL: begin
                    r_weight <= r_weight << 1;
                    r_scaled <= r_scaled << 1;
                end
                OP_SUBSHR: begin
                    if (fits) begin
                        r_rem <= r_rem - r_scaled;
                        r_quo <= r_quo + r_weight[DATA_WIDTH-1:0];
                    end
                    r_weight <= r_weight >> 1;
                    r_scaled <= r_scaled >> 1;
                end
                OP_EMIT: begin
                    r_out_quo <= r_quo;
                    r_out_err <= r_err;
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid: set on emit, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fire && i_ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_quotient     = r_out_quo;
    assign o_divide_error = r_out_err;

endmodule
`default_nettype wire

[src/egd_checker.sv]
// Port-level checks for the Egyptian divider, bound to the top level.
`default_nettype none
module egd_checker #(
    parameter int DATA_WIDTH = 31
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [((DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input wire logic                               m_axis_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Divide error always reports a zero quotient
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("divide error with nonzero quotient");

    // After an input transfer the block works and takes nothing next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind egyptian_divider egd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_egd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for egyptian_divider: random and corner divisions under varied pacing.
module tb_top;

    localparam int          DW          = 31;
    localparam logic [DW-1:0] MAX_VAL   = {DW{1'b1}};
    localparam int          IN_W        = ((2 * DW + 7) / 8) * 8;
    localparam int          OUT_W       = ((DW + 7) / 8) * 8;
    // The drain wait covers the worst division, with slack for the output register.
    localparam int          DRAIN_WAIT  = 2 * DW + 16;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          NUM_PHASES  = 4;

    typedef struct {
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_operand;

    typedef struct {
        logic [DW-1:0] quotient;
        logic          divide_error;
    } t_div_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              s_axis_tvalid  = 1'b0;
    logic              s_axis_tready;
    // [30:0] dividend, [61:31] divisor, [63:62] zero
    logic [IN_W-1:0]   s_axis_tdata   = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready  = 1'b0;
    // [30:0] quotient, [31] zero
    logic [OUT_W-1:0]  m_axis_tdata;
    // [0] divide_error
    logic              m_axis_tuser;

    t_operand          operand_q[$];     // divisions waiting to be driven
    t_div_result       quotient_q[$];    // predicted results in transfer order

    int                idle_pct       = 0;
    int                stall_pct      = 0;
    int                cycle_count    = 0;
    int                mismatch_count = 0;
    int                checked_count  = 0;
    int                accepted_count = 0;
    int                zero_div_count = 0;
    int                directed_count = 0;

    egyptian_divider u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Predict one division: double the divisor and its weight until the divisor
    // reaches the dividend, then subtract wherever it fits, halving both after each try.
    // Registers are one bit wider than the data so the doubling cannot wrap.
    function automatic t_div_result divide_expected(logic [DW-1:0] num, logic [DW-1:0] den);
        t_div_result res;
        logic [DW:0] weight;
        logic [DW:0] scaled;
        logic [DW:0] remain;
        logic [DW:0] acc;
        if (den == '0) begin
            res.quotient     = '0;
            res.divide_error = 1'b1;
            return res;
        end
        weight = (DW+1)'(1);
        scaled = {1'b0, den};
        remain = {1'b0, num};
        acc    = '0;
        while (scaled < remain) begin
            weight = weight << 1;
            scaled = scaled << 1;
        end
        while (weight != '0) begin
            if (scaled <= remain) begin
                acc    = acc + weight;
                remain = remain - scaled;
            end
            weight = weight >> 1;
            scaled = scaled >> 1;
        end
        res.quotient     = acc[DW-1:0];
        res.divide_error = 1'b0;
        return res;
    endfunction

    // Random value with a random bit length, so every normalization depth shows up.
    function automatic logic [DW-1:0] random_magnitude();
        int          len;
        logic [31:0] mask;
        len  = $urandom_range(DW, 0);
        mask = (32'h1 << len) - 32'h1;
        return DW'($urandom & mask);
    endfunction

    task automatic queue_division(logic [DW-1:0] num, logic [DW-1:0] den);
        t_operand op;
        op.dividend = num;
        op.divisor  = den;
        operand_q.push_back(op);
    endtask

    task automatic queue_random_divisions(int count);
        int            pick;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [63:0]   prod;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                // divide by zero with an arbitrary dividend
                num = random_magnitude();
                den = '0;
            end else if (pick < 24) begin
                // full-range operands toggle every bit
                num = DW'($urandom);
                den = DW'($urandom);
            end else if (pick < 36) begin
                // dividend close to a multiple of the divisor: exercises fit/no-fit edges
                den  = random_magnitude();
                if (den == '0) den = DW'(1);
                prod = 64'(den) * 64'($urandom_range(9, 0)) + 64'($urandom_range(2, 0)) - 64'd1;
                num  = (prod > 64'(MAX_VAL)) ? MAX_VAL : prod[DW-1:0];
            end else begin
                num = random_magnitude();
                den = random_magnitude();
                if (den == '0) den = MAX_VAL >> $urandom_range(DW - 1, 0);
            end
            queue_division(num, den);
        end
    endtask

    // Sender: pop the next division when the bus is free, record the prediction
    // on each transfer, and scramble the bus while idle.
    always @(posedge i_clk) begin : stimulus_driver
        t_operand nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                quotient_q.push_back(divide_expected(s_axis_tdata[DW-1:0],
                                                     s_axis_tdata[2*DW-1:DW]));
                accepted_count++;
                if (s_axis_tdata[2*DW-1:DW] == '0) zero_div_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (operand_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = operand_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_W - 2 * DW){1'b0}}, nxt.divisor, nxt.dividend};
                end else begin
                    // hold valid low; the data bus carries junk that must be ignored
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= {$urandom, $urandom};
                end
            end
        end
    end

    // Receiver: stall at random, check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_div_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (quotient_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: unexpected result quotient=%0d err=%0b",
                                 m_axis_tdata[DW-1:0], m_axis_tuser);
                end else begin
                    want = quotient_q.pop_front();
                    checked_count++;
                    if (m_axis_tdata[DW-1:0] !== want.quotient
                            || m_axis_tuser !== want.divide_error) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch #%0d: expected q=%0d err=%0b, got q=%0d err=%0b",
                                     checked_count, want.quotient, want.divide_error,
                                     m_axis_tdata[DW-1:0], m_axis_tuser);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: fail the run once it reaches the cycle limit, as when traffic stops flowing.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, quotient_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : test_sequence
        int phase_idle[NUM_PHASES];
        int phase_stall[NUM_PHASES];
        int phase_items[NUM_PHASES];
        // pacing per phase: free-running, slow sender, slow receiver, light jitter
        phase_idle  = '{0, 88, 0, 9};
        phase_stall = '{0, 0, 88, 9};
        phase_items = '{600, 400, 400, 530};

        // Hold reset low, then release it on a rising edge.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases: zero divisor, zero dividend, extremes and exact fits.
        queue_division('0, '0);
        queue_division(DW'(1), '0);
        queue_division(MAX_VAL, '0);
        queue_division('0, DW'(1));
        queue_division('0, MAX_VAL);
        queue_division(MAX_VAL, DW'(1));
        queue_division(MAX_VAL, MAX_VAL);
        queue_division(DW'(1), MAX_VAL);
        queue_division(DW'(1), DW'(1));
        queue_division(MAX_VAL, DW'(2));
        queue_division(MAX_VAL - DW'(1), MAX_VAL);
        queue_division(MAX_VAL, MAX_VAL - DW'(1));
        queue_division(31'h4000_0000, DW'(1));
        queue_division(31'h4000_0000, 31'h4000_0000);
        queue_division(31'h3FFF_FFFF, 31'h4000_0000);
        queue_division(DW'(7), DW'(3));
        queue_division(DW'(100), DW'(7));
        queue_division(MAX_VAL, DW'(3));
        queue_division(DW'(6), DW'(4));
        queue_division(DW'(1_000_000), DW'(1_000_001));
        queue_division(31'h5555_5555, 31'h2AAA_AAAA);
        queue_division(31'h2AAA_AAAA, 31'h5555_5555);
        directed_count = operand_q.size();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            @(negedge i_clk);
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            queue_random_divisions(phase_items[ph]);
            // advance only once this phase has fully drained
            while (operand_q.size() != 0 || s_axis_tvalid || quotient_q.size() != 0)
                @(negedge i_clk);
        end

        // Let any stray late result surface before judging.
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (quotient_q.size() != 0) mismatch_count++;

        $display("covered %0d divisions (%0d corner, %0d by zero), %0d results checked",
                 accepted_count, directed_count, zero_div_count, checked_count);
        $display("pacing phases: none, slow sender, slow receiver, mixed; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[egyptian_divider.f]
src/egd_pkg.sv
src/egd_seq.sv
src/egd_datapath.sv
src/egyptian_divider.sv
src/egd_checker.sv
bench/tb_top.sv
